/* sv/tmssd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the segment table for the multiplexed
// seven-segment driver. No dependencies.
package tmssd_pkg;

	// Operation codes carried in the op field of an input item.
	localparam logic [1:0] OP_SHOW   = 2'd0;
	localparam logic [1:0] OP_UPDATE = 2'd1;
	localparam logic [1:0] OP_OFF    = 2'd2;

	localparam int DIGIT_COUNT_DEF = 3;
	localparam int SHOWN_DIGITS    = 3;
	localparam int CFG_W           = 8;

	localparam logic [CFG_W-1:0] INTERVAL_RESET = 8'd2;
	localparam logic [9:0]       MAX_SHOWN      = 10'd999;

	typedef logic [SHOWN_DIGITS-1:0][3:0] digit_vec_t;
	typedef logic [SHOWN_DIGITS-1:0]      blank_vec_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] number;
		logic [31:0] now_ms;
		logic [15:0] duration_ms;
	} item_t;

	typedef struct packed {
		logic [6:0] segment_drive;
		logic [2:0] digit_enable;
		logic       display_on;
	} result_t;

	// Common-cathode patterns, bit 6 is segment A down to bit 0 for G.
	function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
		logic [6:0] pat;
		case (digit)
			4'd0: pat = 7'b1111110;
			4'd1: pat = 7'b0110000;
			4'd2: pat = 7'b1101101;
			4'd3: pat = 7'b1111001;
			4'd4: pat = 7'b0110011;
			4'd5: pat = 7'b1011011;
			4'd6: pat = 7'b1011111;
			4'd7: pat = 7'b1110000;
			4'd8: pat = 7'b1111111;
			4'd9: pat = 7'b1111011;
			default: pat = 7'b0000000;
		endcase
		return pat;
	endfunction

endpackage

/* sv/timed_mux_seven_segment_driver.sv */
`timescale 1ns / 1ps
// Top level of the timed, multiplexed three-digit seven-segment driver.
// Depends on tmssd_pkg and tmssd_core.
//
// Usage
// The input channel (in_valid / in_ready) carries one item per handshake:
// op selects show, time update or off; number, now_ms and duration_ms are
// the payload. Every accepted item produces exactly one result item on the
// output channel (out_valid / out_ready): the segment lines, the one-hot
// digit enable and display_on, all as they stand after the item has taken
// effect.
// An item is first captured in the input register; when it moves on, the
// display state is updated and the result is loaded into the output
// register. One item is accepted every cycle while the receiver
// keeps taking results; the whole update for an item is a single pass of
// logic, a constant-reciprocal decimal split and a 32-bit wrapping compare.
// When the receiver stalls, the output register holds its result and the
// input register can still take one more item; after that in_ready drops
// until the result is taken. No item is lost or repeated.
// The multiplex interval is written through cfg_wr_en / cfg_wr_data and
// should only change while no item is in flight.
// Reset clears both registers' valid flags, blanks all digits, turns the
// display off and sets the interval to 2 ms.
module timed_mux_seven_segment_driver #(
	parameter int DIGIT_COUNT = tmssd_pkg::DIGIT_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [15:0]                 number,
	input  logic [31:0]                 now_ms,
	input  logic [15:0]                 duration_ms,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [6:0]                  segment_drive,
	output logic [2:0]                  digit_enable,
	output logic                        display_on,
	input  logic                        cfg_wr_en,
	input  logic [tmssd_pkg::CFG_W-1:0] cfg_wr_data
);

	tmssd_pkg::item_t   item_s1;
	logic               valid_s1;
	tmssd_pkg::result_t result_d, result_q;
	logic               out_valid_q;
	logic               slot_free, fire_s1;

	// The output register is free when empty or being emptied this cycle.
	assign slot_free = !out_valid_q || out_ready;
	assign fire_s1   = valid_s1 && slot_free;
	assign in_ready  = !valid_s1 || slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.op          <= op;
			item_s1.number      <= number;
			item_s1.now_ms      <= now_ms;
			item_s1.duration_ms <= duration_ms;
		end
	end

	tmssd_core #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire_s1),
		.item        (item_s1),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.result      (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			result_q <= result_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign segment_drive = result_q.segment_drive;
	assign digit_enable  = result_q.digit_enable;
	assign display_on    = result_q.display_on;

endmodule

/* sv/tmssd_digit_split.sv */
`timescale 1ns / 1ps
// Saturating binary to three-digit decimal split with leading-zero blanking.
// Depends on tmssd_pkg.
module tmssd_digit_split (
	input  logic [15:0]                number,
	output tmssd_pkg::digit_vec_t      digits,
	output tmssd_pkg::blank_vec_t      blanks
);

	logic [9:0]  value;
	logic [15:0] prod_h;
	logic [3:0]  hund;
	logic [9:0]  rem_w;
	logic [6:0]  rem;
	logic [14:0] prod_t;
	logic [3:0]  tens;
	logic [6:0]  ones_w;

	// Divisions by 100 and 10 use reciprocal multiplies; exact for values up to 999.
	always_comb begin
		value  = (number > 16'(tmssd_pkg::MAX_SHOWN)) ? tmssd_pkg::MAX_SHOWN : number[9:0];
		prod_h = 16'(value) * 16'd41;
		hund   = prod_h[15:12];
		rem_w  = value - 10'(hund) * 10'd100;
		rem    = rem_w[6:0];
		prod_t = 15'(rem) * 15'd205;
		tens   = prod_t[14:11];
		ones_w = rem - 7'(tens) * 7'd10;

		digits    = '0;
		digits[0] = hund;
		digits[1] = tens;
		digits[2] = ones_w[3:0];
		blanks    = '0;
		blanks[0] = (value < 10'd100);
		blanks[1] = (value < 10'd10);
		blanks[2] = 1'b0;
	end

endmodule

/* sv/tmssd_core.sv */
`timescale 1ns / 1ps
// Display state, interval register and per-item next-state logic.
// Depends on tmssd_pkg and tmssd_digit_split.
module tmssd_core #(
	parameter int DIGIT_COUNT = tmssd_pkg::DIGIT_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  tmssd_pkg::item_t               item,
	input  logic                           cfg_wr_en,
	input  logic [tmssd_pkg::CFG_W-1:0]    cfg_wr_data,
	output tmssd_pkg::result_t             result
);

	localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	tmssd_pkg::digit_vec_t digit_q, digit_d, split_digits;
	tmssd_pkg::blank_vec_t blank_q, blank_d, split_blanks;
	logic [POS_W-1:0]      pos_q, pos_d, pos_adv;
	logic [31:0]           deadline_q, deadline_d;
	logic [31:0]           last_q, last_d;
	logic [6:0]            seg_q, seg_d, seg_adv;
	logic [2:0]            en_q, en_d, en_adv;
	logic [tmssd_pkg::CFG_W-1:0] interval_q;

	logic [31:0] diff_cur, diff_nx, elapsed;
	logic        ahead_cur, hold;
	logic [3:0]  pos_ext;

	tmssd_digit_split u_split (
		.number (item.number),
		.digits (split_digits),
		.blanks (split_blanks)
	);

	always_comb begin
		diff_cur  = deadline_q - item.now_ms;
		ahead_cur = (deadline_q != '0) && (diff_cur != '0) && !diff_cur[31];
		elapsed   = item.now_ms - last_q;
		hold      = (last_q != '0) && (elapsed < 32'(interval_q));

		pos_adv = (pos_q == POS_W'(DIGIT_COUNT - 1)) ? '0 : pos_q + 1'b1;
		pos_ext = 4'(pos_adv);

		// Positions past the third are always dark.
		case (pos_ext)
			4'd0: begin
				seg_adv = blank_q[0] ? 7'd0 : tmssd_pkg::seg_pattern(digit_q[0]);
				en_adv  = blank_q[0] ? 3'b000 : 3'b001;
			end
			4'd1: begin
				seg_adv = blank_q[1] ? 7'd0 : tmssd_pkg::seg_pattern(digit_q[1]);
				en_adv  = blank_q[1] ? 3'b000 : 3'b010;
			end
			4'd2: begin
				seg_adv = blank_q[2] ? 7'd0 : tmssd_pkg::seg_pattern(digit_q[2]);
				en_adv  = blank_q[2] ? 3'b000 : 3'b100;
			end
			default: begin
				seg_adv = 7'd0;
				en_adv  = 3'b000;
			end
		endcase

		digit_d    = digit_q;
		blank_d    = blank_q;
		pos_d      = pos_q;
		deadline_d = deadline_q;
		last_d     = last_q;
		seg_d      = seg_q;
		en_d       = en_q;

		case (item.op)
			tmssd_pkg::OP_SHOW: begin
				digit_d    = split_digits;
				blank_d    = split_blanks;
				deadline_d = item.now_ms + 32'(item.duration_ms);
				last_d     = '0;
			end
			tmssd_pkg::OP_UPDATE: begin
				if (!ahead_cur) begin
					deadline_d = '0;
					seg_d      = '0;
					en_d       = '0;
				end else if (!hold) begin
					last_d = item.now_ms;
					pos_d  = pos_adv;
					seg_d  = seg_adv;
					en_d   = en_adv;
				end
			end
			tmssd_pkg::OP_OFF: begin
				deadline_d = '0;
				seg_d      = '0;
				en_d       = '0;
			end
			default: begin
				digit_d = digit_q;
			end
		endcase

		diff_nx              = deadline_d - item.now_ms;
		result.segment_drive = seg_d;
		result.digit_enable  = en_d;
		result.display_on    = (deadline_d != '0) && (diff_nx != '0) && !diff_nx[31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q    <= '0;
			blank_q    <= '1;
			pos_q      <= '0;
			deadline_q <= '0;
			last_q     <= '0;
			seg_q      <= '0;
			en_q       <= '0;
		end else if (fire) begin
			digit_q    <= digit_d;
			blank_q    <= blank_d;
			pos_q      <= pos_d;
			deadline_q <= deadline_d;
			last_q     <= last_d;
			seg_q      <= seg_d;
			en_q       <= en_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= tmssd_pkg::INTERVAL_RESET;
		end else if (cfg_wr_en) begin
			interval_q <= cfg_wr_data;
		end
	end

endmodule

/* sv/tmssd_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the seven-segment driver, bound to its top level.
// Depends on timed_mux_seven_segment_driver.
module tmssd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] segment_drive,
	input logic [2:0] digit_enable,
	input logic       display_on
);

	// At most one digit is driven at a time.
	a_enable_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(digit_enable))
		else $error("more than one digit enabled");

	// Segments light exactly when some digit is enabled.
	a_seg_with_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((segment_drive == 7'd0) == (digit_enable == 3'd0)))
		else $error("segment lines and digit enable disagree");

	// A result appearing on an empty output follows an item accepted into the input register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching item");

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(segment_drive)
			&& $stable(digit_enable) && $stable(display_on)))
		else $error("stalled result changed");

endmodule

bind timed_mux_seven_segment_driver tmssd_checker u_tmssd_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for the timed, multiplexed three-digit seven-segment driver.
// Depends on tmssd_pkg and timed_mux_seven_segment_driver; nothing else is read.
module testbench;

	// The one op code that the package leaves unnamed: the driver must ignore it.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Common-cathode glyphs, seven bits each, digit 0 in the lowest seven bits.
	localparam logic [69:0] GLYPHS = {
		7'b1111011, 7'b1111111, 7'b1110000, 7'b1011111, 7'b1011011,
		7'b0110011, 7'b1111001, 7'b1101101, 7'b0110000, 7'b1111110
	};

	localparam int IDLE_PERCENT = 31;
	localparam int REPORT_LIMIT = 10;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [1:0]  op          = tmssd_pkg::OP_UPDATE;
	logic [15:0] number      = 16'd0;
	logic [31:0] now_ms      = 32'd0;
	logic [15:0] duration_ms = 16'd0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [6:0]  segment_drive;
	logic [2:0]  digit_enable;
	logic        display_on;
	logic        cfg_wr_en   = 1'b0;
	logic [tmssd_pkg::CFG_W-1:0] cfg_wr_data = '0;

	timed_mux_seven_segment_driver u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.number        (number),
		.now_ms        (now_ms),
		.duration_ms   (duration_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.segment_drive (segment_drive),
		.digit_enable  (digit_enable),
		.display_on    (display_on),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	// 10 ns period, high and low halves.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Display model. It keeps its own copy of everything the driver holds:
	// the three stored digits with their blanking marks, the digit being
	// shown, the visibility deadline, the time of the last digit advance,
	// the two drive registers and the multiplex interval.
	// ------------------------------------------------------------------
	logic [3:0]  shown_digit [3];
	logic [2:0]  blanked;
	logic [1:0]  lit_position;
	logic [31:0] off_deadline;
	logic [31:0] last_step_ms;
	logic [6:0]  seg_reg;
	logic [2:0]  en_reg;
	logic [7:0]  mux_interval;

	task automatic clear_display_model();
		for (int i = 0; i < 3; i++)
			shown_digit[i] = 4'd0;
		blanked      = 3'b111;
		lit_position = 2'd0;
		off_deadline = 32'd0;
		last_step_ms = 32'd0;
		seg_reg      = 7'd0;
		en_reg       = 3'd0;
		mux_interval = tmssd_pkg::INTERVAL_RESET;
	endtask

	// The display counts as on while the deadline is non-zero and still lies
	// strictly ahead of the given time, judged as a signed 32-bit distance so
	// that the comparison survives the wrap of the millisecond counter.
	function automatic logic deadline_pending(input logic [31:0] at_ms);
		logic [31:0] gap;
		gap = off_deadline - at_ms;
		return off_deadline != 32'd0 && gap != 32'd0 && !gap[31];
	endfunction

	task automatic step_display(input tmssd_pkg::item_t it, output tmssd_pkg::result_t res);
		int          value;
		logic [31:0] since;
		case (it.op)
			tmssd_pkg::OP_SHOW: begin
				// Saturate, split into decimal digits and blank leading zeros.
				value = (it.number > tmssd_pkg::MAX_SHOWN) ?
					int'(tmssd_pkg::MAX_SHOWN) : int'(it.number);
				shown_digit[0] = 4'(value / 100);
				shown_digit[1] = 4'((value / 10) % 10);
				shown_digit[2] = 4'(value % 10);
				blanked      = {1'b0, value < 10, value < 100};
				off_deadline = it.now_ms + {16'd0, it.duration_ms};
				last_step_ms = 32'd0;
			end
			tmssd_pkg::OP_UPDATE: begin
				since = it.now_ms - last_step_ms;
				if (!deadline_pending(it.now_ms)) begin
					off_deadline = 32'd0;
					seg_reg      = 7'd0;
					en_reg       = 3'd0;
				end else if (last_step_ms == 32'd0 || since >= {24'd0, mux_interval}) begin
					// A zero last-advance time means the multiplexer has just
					// been rearmed, so it moves on at once.
					last_step_ms = it.now_ms;
					lit_position = (lit_position == 2'd2) ? 2'd0 : lit_position + 2'd1;
					seg_reg      = 7'd0;
					en_reg       = 3'd0;
					if (!blanked[lit_position]) begin
						seg_reg = GLYPHS[int'(shown_digit[lit_position]) * 7 +: 7];
						en_reg  = 3'b001 << lit_position;
					end
				end
			end
			tmssd_pkg::OP_OFF: begin
				off_deadline = 32'd0;
				seg_reg      = 7'd0;
				en_reg       = 3'd0;
			end
			default: ;
		endcase
		res.segment_drive = seg_reg;
		res.digit_enable  = en_reg;
		res.display_on    = deadline_pending(it.now_ms);
	endtask

	// ------------------------------------------------------------------
	// Shared state of the bench.
	// ------------------------------------------------------------------
	tmssd_pkg::item_t   item_backlog [$];   // items waiting for the driver
	tmssd_pkg::result_t awaited_drive [$];  // predicted outputs, oldest first
	logic    calm = 1'b0;        // while set, neither side idles
	logic    in_taken = 1'b0;    // the item on the bus was accepted at the last edge
	int      mismatches = 0;
	int      op_seen [4] = '{0, 0, 0, 0};
	int      lit_results = 0;
	int      results_seen = 0;

	// Sender: offers the next item at the falling edge, holding the current one
	// until it has been accepted, and idles at random unless the bench is calm.
	always @(negedge clk) begin
		tmssd_pkg::item_t nxt;
		if (arst_n && (!in_valid || in_taken)) begin
			if (item_backlog.size() != 0 &&
			    (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
				nxt = item_backlog.pop_front();
				in_valid    <= 1'b1;
				op          <= nxt.op;
				number      <= nxt.number;
				now_ms      <= nxt.now_ms;
				duration_ms <= nxt.duration_ms;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stalls the result channel at random, never while calm.
	always @(negedge clk) begin
		if (arst_n)
			out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	// Monitor: at each rising edge it checks a delivered result against the
	// oldest prediction, then runs the model on an item accepted at this edge.
	// A register write is mirrored into the model at the same edge.
	always @(posedge clk) begin
		tmssd_pkg::item_t   it;
		tmssd_pkg::result_t want;
		if (arst_n) begin
			if (cfg_wr_en)
				mux_interval = cfg_wr_data;
			if (out_valid && out_ready) begin
				results_seen++;
				if (digit_enable != 3'd0)
					lit_results++;
				if (awaited_drive.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected result at %0t: seg %b en %b on %b",
							$time, segment_drive, digit_enable, display_on);
				end else begin
					want = awaited_drive.pop_front();
					if (segment_drive !== want.segment_drive ||
					    digit_enable !== want.digit_enable ||
					    display_on !== want.display_on) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("mismatch at %0t: expected seg %b en %b on %b,",
								$time, want.segment_drive, want.digit_enable,
								want.display_on, " got seg %b en %b on %b",
								segment_drive, digit_enable, display_on);
					end
				end
			end
			in_taken = in_valid && in_ready;
			if (in_taken) begin
				it.op          = op;
				it.number      = number;
				it.now_ms      = now_ms;
				it.duration_ms = duration_ms;
				step_display(it, want);
				awaited_drive.push_back(want);
				op_seen[op]++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------
	logic [31:0] clock_ms = 32'd0;   // running millisecond clock of the random traffic

	task automatic enqueue_item(input logic [1:0] o, input logic [15:0] num,
	                            input logic [31:0] at_ms, input logic [15:0] dur);
		tmssd_pkg::item_t it;
		it.op          = o;
		it.number      = num;
		it.now_ms      = at_ms;
		it.duration_ms = dur;
		item_backlog.push_back(it);
	endtask

	// Values spread over every digit count, the saturation limit and the full field.
	function automatic logic [15:0] pick_number();
		logic [15:0] edges [4];
		edges = '{16'd0, 16'd999, 16'd1000, 16'hFFFF};
		case ($urandom_range(0, 9))
			0, 1:    return 16'($urandom_range(0, 9));
			2, 3:    return 16'($urandom_range(10, 99));
			4, 5, 6: return 16'($urandom_range(100, 999));
			7:       return 16'($urandom_range(1000, 65535));
			8:       return 16'($urandom());
			default: return edges[$urandom_range(0, 3)];
		endcase
	endfunction

	// Mostly short enough for the deadline to expire within a run of updates.
	function automatic logic [15:0] pick_duration(input logic [7:0] iv);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, 4 * int'(iv) + 30));
			6:                return 16'd0;
			7:                return 16'($urandom());
			default:          return 16'($urandom_range(1, 12 * int'(iv) + 60));
		endcase
	endfunction

	// Mostly well-formed traffic: a show followed by a run of time updates that
	// walk the clock forward at about the multiplex pace, with the odd off or
	// unused code inside the run. The rest is noise: lone updates at arbitrary
	// times, offs, unused codes and shows with arbitrary fields.
	task automatic plan_traffic(input int count, input logic [7:0] iv);
		int          made;
		int          run;
		int          r;
		logic [15:0] dur;
		made = 0;
		while (made < count) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				if ($urandom_range(0, 9) == 0)
					clock_ms = $urandom();
				else if ($urandom_range(0, 19) == 0)
					clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 600));
				dur = pick_duration(iv);
				// Now and then the deadline lands exactly on zero after the wrap.
				if ($urandom_range(0, 24) == 0 && dur != 16'd0)
					clock_ms = 32'd0 - {16'd0, dur};
				enqueue_item(tmssd_pkg::OP_SHOW, pick_number(), clock_ms, dur);
				run = $urandom_range(2, 20);
				for (int k = 0; k < run; k++) begin
					if ($urandom_range(0, 7) == 0)
						clock_ms = clock_ms + 32'($urandom_range(0, 3 * int'(iv) + 5));
					else
						clock_ms = clock_ms + 32'($urandom_range(0, int'(iv) + 2));
					r = $urandom_range(0, 99);
					if (r < 4)
						enqueue_item(tmssd_pkg::OP_OFF, 16'($urandom()), clock_ms,
							16'($urandom()));
					else if (r < 7)
						enqueue_item(OP_UNUSED, 16'($urandom()), clock_ms,
							16'($urandom()));
					else
						enqueue_item(tmssd_pkg::OP_UPDATE, 16'($urandom()), clock_ms,
							16'($urandom()));
				end
				made += run + 1;
			end else begin
				case ($urandom_range(0, 4))
					0: enqueue_item(tmssd_pkg::OP_UPDATE, 16'($urandom()), $urandom(),
						16'($urandom()));
					1: enqueue_item(tmssd_pkg::OP_OFF, 16'($urandom()), clock_ms,
						16'($urandom()));
					2: enqueue_item(OP_UNUSED, 16'($urandom()), $urandom(), 16'($urandom()));
					3: enqueue_item(tmssd_pkg::OP_SHOW, 16'($urandom()), $urandom(),
						16'($urandom()));
					default: enqueue_item(tmssd_pkg::OP_UPDATE, 16'($urandom()),
						clock_ms - 32'($urandom_range(1, 300)), 16'($urandom()));
				endcase
				made++;
			end
		end
	endtask

	// Returns at a falling edge once nothing is queued, offered or outstanding.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (item_backlog.size() != 0 || in_valid || awaited_drive.size() != 0);
	endtask

	// One-cycle register write; the model follows at the same rising edge.
	task automatic write_interval(input int value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= tmssd_pkg::CFG_W'(value);
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	int interval_plan [6];

	initial begin
		clear_display_model();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset interval of two milliseconds.
		write_interval(2);
		// An update straight after reset finds the deadline at zero, so the
		// display stays off.
		enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd0, 16'd0);
		// Show zero: only the rightmost digit is lit, the others are blanked.
		enqueue_item(tmssd_pkg::OP_SHOW, 16'd0, 32'd100, 16'd10);
		enqueue_item(tmssd_pkg::OP_UPDATE, 16'hFFFF, 32'd100, 16'hFFFF);
		enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd101, 16'd0);
		enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd102, 16'd0);
		enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd104, 16'd0);
		// Reaching the deadline exactly turns the display off.
		enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd110, 16'd0);
		// The largest number saturates to 999 and every digit is lit in turn.
		enqueue_item(tmssd_pkg::OP_SHOW, 16'hFFFF, 32'd200, 16'hFFFF);
		enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd200, 16'd0);
		enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd202, 16'd0);
		enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd204, 16'd0);
		enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd206, 16'd0);
		// The unused code changes nothing.
		enqueue_item(OP_UNUSED, 16'h5A5A, 32'd207, 16'hA5A5);
		// A show leaves the drive registers as they stand.
		enqueue_item(tmssd_pkg::OP_SHOW, 16'd42, 32'd210, 16'd20);
		enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd210, 16'd0);
		// Off, then an update that finds no deadline.
		enqueue_item(tmssd_pkg::OP_OFF, 16'd0, 32'd211, 16'd0);
		enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd212, 16'd0);
		// Deadline that wraps round to zero means off.
		enqueue_item(tmssd_pkg::OP_SHOW, 16'd999, 32'hFFFF_FFF0, 16'h0010);
		enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'hFFFF_FFF1, 16'd0);
		// Deadline just past the wrap; an advance at time zero rearms the
		// multiplexer, so the next updates advance at once as well.
		enqueue_item(tmssd_pkg::OP_SHOW, 16'd7, 32'hFFFF_FFFE, 16'd100);
		enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd0, 16'd0);
		enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd0, 16'd0);
		enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd1, 16'd0);
		// Either side of half the counter range from the deadline.
		enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'h8000_0063, 16'd0);
		enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'h8000_0062, 16'd0);
		// Pause here until every result of the directed part has come back.
		wait_drained();

		// Random phases, each at its own interval. The fifth runs with no idling.
		interval_plan = '{0, 1, 255, $urandom_range(3, 254), 2, $urandom_range(1, 255)};
		for (int p = 0; p < 6; p++) begin
			write_interval(interval_plan[p]);
			if (interval_plan[p] == 0) begin
				// With a zero interval every update that finds the display on
				// moves to the next digit, even at the same millisecond.
				enqueue_item(tmssd_pkg::OP_SHOW, 16'd5, 32'd1000, 16'd50);
				enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd1000, 16'd0);
				enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd1000, 16'd0);
				enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd1000, 16'd0);
				enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd1049, 16'd0);
				enqueue_item(tmssd_pkg::OP_UPDATE, 16'd0, 32'd1050, 16'd0);
			end
			calm = (p == 4);
			plan_traffic(310, tmssd_pkg::CFG_W'(interval_plan[p]));
			wait_drained();
			calm = 1'b0;
		end

		// Let the pipeline settle so that a stray result would still be caught.
		repeat (8) @(negedge clk);

		$display("run covered %0d show, %0d update, %0d off and %0d unused-code items;",
			op_seen[tmssd_pkg::OP_SHOW], op_seen[tmssd_pkg::OP_UPDATE],
			op_seen[tmssd_pkg::OP_OFF], op_seen[OP_UNUSED]);
		$display("%0d results checked (%0d with a digit lit), intervals 2 %0d %0d %0d %0d %0d %0d",
			results_seen, lit_results, interval_plan[0], interval_plan[1], interval_plan[2],
			interval_plan[3], interval_plan[4], interval_plan[5]);
		if (mismatches == 0 && awaited_drive.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
sv/tmssd_pkg.sv
sv/tmssd_digit_split.sv
sv/tmssd_core.sv
sv/timed_mux_seven_segment_driver.sv
sv/tmssd_checker.sv
tb/testbench.sv
